// ----- rtl/elfx_pkg.sv -----
// ----------------------------------------------------------------------------
// elfx_pkg
// Types, relocation type codes and the type decoder shared by the x86-64
// relocation value blocks.
// ----------------------------------------------------------------------------
package elfx_pkg;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [1:0] CFG_GOT_ADDRESS         = 2'd0;
	localparam logic [1:0] CFG_SECTION_ADDRESS     = 2'd1;
	localparam logic [1:0] CFG_SECTION_FILE_OFFSET = 2'd2;

	localparam logic [1:0] NOTE_WEAK     = 2'd1;
	localparam logic [1:0] NOTE_ABSOLUTE = 2'd2;

	localparam logic [7:0] RELOC_NONE          = 8'd0;
	localparam logic [7:0] RELOC_ABS64         = 8'd1;
	localparam logic [7:0] RELOC_PC32          = 8'd2;
	localparam logic [7:0] RELOC_GOT32         = 8'd3;
	localparam logic [7:0] RELOC_PLT32         = 8'd4;
	localparam logic [7:0] RELOC_GLOB_DAT      = 8'd6;
	localparam logic [7:0] RELOC_JUMP_SLOT     = 8'd7;
	localparam logic [7:0] RELOC_GOTPCREL      = 8'd9;
	localparam logic [7:0] RELOC_ABS32         = 8'd10;
	localparam logic [7:0] RELOC_ABS32S        = 8'd11;
	localparam logic [7:0] RELOC_ABS16         = 8'd12;
	localparam logic [7:0] RELOC_PC16          = 8'd13;
	localparam logic [7:0] RELOC_ABS8          = 8'd14;
	localparam logic [7:0] RELOC_PC8           = 8'd15;
	localparam logic [7:0] RELOC_PC64          = 8'd24;
	localparam logic [7:0] RELOC_GOTOFF64      = 8'd25;
	localparam logic [7:0] RELOC_GOTPC32       = 8'd26;
	localparam logic [7:0] RELOC_GOT64         = 8'd27;
	localparam logic [7:0] RELOC_GOTPCREL64    = 8'd28;
	localparam logic [7:0] RELOC_GOTPC64       = 8'd29;
	localparam logic [7:0] RELOC_SIZE32        = 8'd32;
	localparam logic [7:0] RELOC_SIZE64        = 8'd33;
	localparam logic [7:0] RELOC_GOTPCRELX     = 8'd41;
	localparam logic [7:0] RELOC_REX_GOTPCRELX = 8'd42;

	localparam logic [3:0] BYTES_0 = 4'd0;
	localparam logic [3:0] BYTES_1 = 4'd1;
	localparam logic [3:0] BYTES_2 = 4'd2;
	localparam logic [3:0] BYTES_4 = 4'd4;
	localparam logic [3:0] BYTES_8 = 4'd8;

	typedef enum logic [1:0] {
		T1_ZERO,
		T1_S,
		T1_SYM,
		T1_GOT
	} t1_sel_t;

	typedef enum logic [1:0] {
		T3_ZERO,
		T3_P,
		T3_GOT
	} t3_sel_t;

	typedef struct packed {
		t1_sel_t    t1;
		logic       add_got;
		logic       use_addend;
		t3_sel_t    t3;
		logic [3:0] bytes;
		logic       unsupported;
	} decode_t;

	typedef struct packed {
		decode_t     dec;
		logic [63:0] s;
		logic [63:0] sym;
		logic [63:0] p;
		logic [63:0] addend;
		logic [62:0] fpos;
	} item_t;

	// The value is (T1 + optional GOT) + (optional A - T3).
	function automatic decode_t decode_op(input logic [7:0] code);
		decode_t d;
		d = '{t1: T1_ZERO, add_got: 1'b0, use_addend: 1'b0, t3: T3_ZERO,
			bytes: BYTES_0, unsupported: 1'b0};
		unique case (code) inside
			RELOC_NONE: begin
			end
			RELOC_ABS64: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.bytes = BYTES_8;
			end
			RELOC_PC32, RELOC_PLT32: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.t3 = T3_P; d.bytes = BYTES_4;
			end
			RELOC_GOT32, RELOC_SIZE32: begin
				d.t1 = T1_SYM; d.use_addend = 1'b1; d.bytes = BYTES_4;
			end
			RELOC_GLOB_DAT, RELOC_JUMP_SLOT: begin
				d.t1 = T1_S; d.bytes = BYTES_8;
			end
			RELOC_GOTPCREL, RELOC_GOTPCRELX, RELOC_REX_GOTPCRELX: begin
				d.t1 = T1_SYM; d.add_got = 1'b1; d.use_addend = 1'b1;
				d.t3 = T3_P; d.bytes = BYTES_4;
			end
			RELOC_ABS32, RELOC_ABS32S: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.bytes = BYTES_4;
			end
			RELOC_ABS16: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.bytes = BYTES_2;
			end
			RELOC_PC16: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.t3 = T3_P; d.bytes = BYTES_2;
			end
			RELOC_ABS8: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.bytes = BYTES_1;
			end
			RELOC_PC8: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.t3 = T3_P; d.bytes = BYTES_1;
			end
			RELOC_PC64: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.t3 = T3_P; d.bytes = BYTES_8;
			end
			RELOC_GOTOFF64: begin
				d.t1 = T1_S; d.use_addend = 1'b1; d.t3 = T3_GOT; d.bytes = BYTES_8;
			end
			RELOC_GOTPC32: begin
				d.t1 = T1_GOT; d.use_addend = 1'b1; d.t3 = T3_P; d.bytes = BYTES_4;
			end
			RELOC_GOT64, RELOC_SIZE64: begin
				d.t1 = T1_SYM; d.use_addend = 1'b1; d.bytes = BYTES_8;
			end
			RELOC_GOTPCREL64: begin
				d.t1 = T1_SYM; d.add_got = 1'b1; d.use_addend = 1'b1;
				d.t3 = T3_P; d.bytes = BYTES_8;
			end
			RELOC_GOTPC64: begin
				d.t1 = T1_GOT; d.use_addend = 1'b1; d.t3 = T3_P; d.bytes = BYTES_8;
			end
			default: begin
				d.unsupported = 1'b1;
			end
		endcase
		return d;
	endfunction

endpackage

// ----- rtl/elfx_front.sv -----
// ----------------------------------------------------------------------------
// elfx_front
// Accepts relocation records, decodes the type and forms S, P and the file
// position into one registered stage.
// ----------------------------------------------------------------------------
module elfx_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           op,
	input  logic [1:0]           symbol_note,
	input  logic signed [63:0]   addend,
	input  logic [63:0]          symbol_value,
	input  logic [63:0]          symbol_section_base,
	input  logic [63:0]          patch_offset,
	input  logic [63:0]          section_address,
	input  logic [62:0]          section_file_offset,
	output logic                 item_valid,
	input  logic                 item_ready,
	output elfx_pkg::item_t      item
);
	import elfx_pkg::*;

	logic        v_s1;
	item_t       item_s1;
	logic [63:0] s_sum;

	assign in_ready   = !v_s1 || item_ready;
	assign item_valid = v_s1;
	assign item       = item_s1;

	always_comb begin
		case (symbol_note)
			NOTE_WEAK:     s_sum = '0;
			NOTE_ABSOLUTE: s_sum = symbol_value;
			default:       s_sum = symbol_section_base + symbol_value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.dec    <= decode_op(op);
			item_s1.s      <= s_sum;
			item_s1.sym    <= symbol_value;
			item_s1.p      <= section_address + patch_offset;
			item_s1.addend <= $unsigned(addend);
			item_s1.fpos   <= section_file_offset + patch_offset[62:0];
		end
	end

`ifndef SYNTHESIS
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && !item_ready |=> v_s1 && $stable(item_s1))
		else $error("front stage changed while stalled");
`endif

endmodule

// ----- rtl/elfx_queue.sv -----
// ----------------------------------------------------------------------------
// elfx_queue
// Short queue of decoded records between the front and the back.
// ----------------------------------------------------------------------------
module elfx_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push_valid,
	output logic                 push_ready,
	input  elfx_pkg::item_t      push_item,
	output logic                 pop_valid,
	input  logic                 pop_ready,
	output elfx_pkg::item_t      pop_item
);
	import elfx_pkg::*;

	item_t                  entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [QUEUE_CNT_W-1:0] count_q;
	logic                   push;
	logic                   pop;

	assign push_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_item   = entry_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");
`endif

endmodule

// ----- rtl/elfx_back.sv -----
// ----------------------------------------------------------------------------
// elfx_back
// Forms the patch value in two add stages and holds the result for the
// receiver.
// ----------------------------------------------------------------------------
module elfx_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  elfx_pkg::item_t      item,
	input  logic [63:0]          got_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          patch_value,
	output logic [3:0]           patch_bytes,
	output logic [62:0]          file_position,
	output logic                 unsupported
);
	import elfx_pkg::*;

	logic        v_b1;
	logic [63:0] u_b1;
	logic [63:0] w_b1;
	logic [3:0]  bytes_b1;
	logic [62:0] fpos_b1;
	logic        unsup_b1;
	logic        v_b2;
	logic        adv_b1;
	logic        adv_b2;
	logic [63:0] t1;
	logic [63:0] t2;
	logic [63:0] t3;
	logic [63:0] a_term;

	assign adv_b2     = !v_b2 || out_ready;
	assign adv_b1     = !v_b1 || adv_b2;
	assign item_ready = adv_b1;
	assign out_valid  = v_b2;

	always_comb begin
		case (item.dec.t1)
			T1_S:    t1 = item.s;
			T1_SYM:  t1 = item.sym;
			T1_GOT:  t1 = got_address;
			default: t1 = '0;
		endcase
		case (item.dec.t3)
			T3_P:    t3 = item.p;
			T3_GOT:  t3 = got_address;
			default: t3 = '0;
		endcase
		t2     = item.dec.add_got ? got_address : '0;
		a_term = item.dec.use_addend ? item.addend : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
		end else begin
			if (adv_b1) begin
				v_b1 <= item_valid;
			end
			if (adv_b2) begin
				v_b2 <= v_b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_b1 && item_valid) begin
			u_b1     <= t1 + t2;
			w_b1     <= a_term - t3;
			bytes_b1 <= item.dec.bytes;
			fpos_b1  <= item.fpos;
			unsup_b1 <= item.dec.unsupported;
		end
		if (adv_b2 && v_b1) begin
			patch_value   <= u_b1 + w_b1;
			patch_bytes   <= bytes_b1;
			file_position <= fpos_b1;
			unsupported   <= unsup_b1;
		end
	end

`ifndef SYNTHESIS
	a_unsup_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_b2 && unsupported |-> patch_bytes == BYTES_0 && patch_value == '0)
		else $error("unsupported record produced a patch");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_b2 && !out_ready |=> v_b2)
		else $error("result dropped while stalled");
`endif

endmodule

// ----- rtl/elf_x86_64_relocation_value.sv -----
// ----------------------------------------------------------------------------
// elf_x86_64_relocation_value
// Computes the patch value, width and file position of x86-64 relocations.
// ----------------------------------------------------------------------------
// Usage:
// Records enter on the in_valid / in_ready channel, one beat per record, and
// results leave on the out_valid / out_ready channel, one beat per record, in
// order. The GOT address, section address and section file offset are set
// through cfg_write / cfg_index / cfg_data; the user must write them only
// while no record is in flight, which the block does not enforce; an index
// beyond the last register is ignored.
// One record is accepted every cycle while the receiver takes results; the
// front stage, a two-entry queue and two back add stages make up the path,
// and the 64-bit adders in each stage set the cycle.
// When the receiver stalls, the result stays on the outputs and the queue
// and front stage fill before in_ready falls.
// Reset clears the configuration registers to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module elf_x86_64_relocation_value (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [1:0]           cfg_index,
	input  logic [63:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           op,
	input  logic [1:0]           symbol_note,
	input  logic signed [63:0]   addend,
	input  logic [63:0]          symbol_value,
	input  logic [63:0]          symbol_section_base,
	input  logic [63:0]          patch_offset,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [63:0]          patch_value,
	output logic [3:0]           patch_bytes,
	output logic [62:0]          file_position,
	output logic                 unsupported
);
	import elfx_pkg::*;

	logic [63:0] got_address_q;
	logic [63:0] section_address_q;
	logic [62:0] section_file_offset_q;
	logic        front_valid;
	logic        front_ready;
	item_t       front_item;
	logic        back_valid;
	logic        back_ready;
	item_t       back_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			got_address_q         <= '0;
			section_address_q     <= '0;
			section_file_offset_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_GOT_ADDRESS:         got_address_q         <= cfg_data;
				CFG_SECTION_ADDRESS:     section_address_q     <= cfg_data;
				CFG_SECTION_FILE_OFFSET: section_file_offset_q <= cfg_data[62:0];
				default: begin
				end
			endcase
		end
	end

	elfx_front u_front (
		.clk                 (clk),
		.arst_n              (arst_n),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.op                  (op),
		.symbol_note         (symbol_note),
		.addend              (addend),
		.symbol_value        (symbol_value),
		.symbol_section_base (symbol_section_base),
		.patch_offset        (patch_offset),
		.section_address     (section_address_q),
		.section_file_offset (section_file_offset_q),
		.item_valid          (front_valid),
		.item_ready          (front_ready),
		.item                (front_item)
	);

	elfx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_item  (front_item),
		.pop_valid  (back_valid),
		.pop_ready  (back_ready),
		.pop_item   (back_item)
	);

	elfx_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (back_valid),
		.item_ready    (back_ready),
		.item          (back_item),
		.got_address   (got_address_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.patch_value   (patch_value),
		.patch_bytes   (patch_bytes),
		.file_position (file_position),
		.unsupported   (unsupported)
	);

endmodule
